FILE: design/complex_matrix_vector_multiply_top_assert.svh
// assertion macros for the complex matrix-vector multiplier
// every macro clocks on clk_i and is disabled while rst_ni is low
`ifndef COMPLEX_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define COMPLEX_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication
`define CMV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmv assertion failed");

// next-cycle implication
`define CMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmv assertion failed");

`endif

FILE: design/cmv_pkg.sv
// shared widths, types and constants of the complex matrix-vector multiplier
// no dependencies
package cmv_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 65536;
  localparam int ColW       = $clog2(MaxColumns);   // column index into the vector store
  localparam int LoadW      = ColW + 1;             // load position, can reach MaxColumns
  localparam int ColTotW    = 11;
  localparam int RowTotW    = 17;
  localparam int RowW       = 16;
  localparam int ValW       = 16;
  localparam int ProdW      = 2 * ValW + 1;
  localparam int AccW       = 48;
  localparam int DataW      = 32;
  localparam int AddrW      = 3;

  // register indexes (paddr[2])
  localparam logic RegRowTotal = 1'b0;
  localparam logic RegColTotal = 1'b1;

  // input function codes
  localparam logic FuncVecLoad = 1'b0;
  localparam logic FuncMatElem = 1'b1;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [ColTotW-1:0] cols;
    logic [RowTotW-1:0] rows;
  } cfg_t;

  // first stage: operands and row bookkeeping of one matrix element
  typedef struct packed {
    logic                   valid;
    logic                   row_end;
    logic                   last;
    logic [RowW-1:0]        row_idx;
    logic signed [ValW-1:0] ar;
    logic signed [ValW-1:0] ai;
    logic signed [ValW-1:0] br;
    logic signed [ValW-1:0] bi;
  } s1_t;

endpackage

FILE: design/cmv_item_if.sv
// input item channel: valid/ready handshake with element payload
// depends on cmv_pkg
interface cmv_item_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [cmv_pkg::ValW-1:0] value_re;
  logic signed [cmv_pkg::ValW-1:0] value_im;

  modport source (output valid, output func, output value_re, output value_im, input ready);
  modport sink   (input valid, input func, input value_re, input value_im, output ready);
endinterface

FILE: design/cmv_result_if.sv
// result item channel: valid/ready handshake with row sum payload
// depends on cmv_pkg
interface cmv_result_if;
  logic                            valid;
  logic                            ready;
  logic [cmv_pkg::RowW-1:0]        row_index;
  logic signed [cmv_pkg::AccW-1:0] sum_re;
  logic signed [cmv_pkg::AccW-1:0] sum_im;
  logic                            last_row;

  modport source (output valid, output row_index, output sum_re, output sum_im,
                  output last_row, input ready);
  modport sink   (input valid, input row_index, input sum_re, input sum_im,
                  input last_row, output ready);
endinterface

FILE: design/cmv_cfg_regs.sv
// apb register file: row_total and column_total, clamped for the datapath
// depends on cmv_pkg
module cmv_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cmv_pkg::AddrW-1:0]  paddr,
  input  logic [cmv_pkg::DataW-1:0]  pwdata,
  output logic [cmv_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output cmv_pkg::cfg_t              cfg_o
);

  logic [cmv_pkg::RowTotW-1:0] row_total_q;
  logic [cmv_pkg::ColTotW-1:0] col_total_q;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_total_q <= cmv_pkg::RowTotW'(1);
      col_total_q <= cmv_pkg::ColTotW'(1);
    end else if (wr_en) begin
      case (paddr[2])
        cmv_pkg::RegRowTotal: row_total_q <= pwdata[cmv_pkg::RowTotW-1:0];
        cmv_pkg::RegColTotal: col_total_q <= pwdata[cmv_pkg::ColTotW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      cmv_pkg::RegRowTotal: prdata = cmv_pkg::DataW'(row_total_q);
      cmv_pkg::RegColTotal: prdata = cmv_pkg::DataW'(col_total_q);
      default:              prdata = '0;
    endcase
  end

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    if (col_total_q == '0)
      cfg_o.cols = cmv_pkg::ColTotW'(1);
    else if (col_total_q > cmv_pkg::ColTotW'(cmv_pkg::MaxColumns))
      cfg_o.cols = cmv_pkg::ColTotW'(cmv_pkg::MaxColumns);
    else
      cfg_o.cols = col_total_q;

    if (row_total_q == '0)
      cfg_o.rows = cmv_pkg::RowTotW'(1);
    else if (row_total_q > cmv_pkg::RowTotW'(cmv_pkg::MaxRows))
      cfg_o.rows = cmv_pkg::RowTotW'(cmv_pkg::MaxRows);
    else
      cfg_o.rows = row_total_q;
  end

endmodule

FILE: design/cmv_seq.sv
// front end: vector store, load/column/row counters and the operand stage
// depends on cmv_pkg
module cmv_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmv_pkg::cfg_t                   cfg_i,
  input  logic                            advance_i,
  input  logic                            in_valid_i,
  input  logic                            func_i,
  input  logic signed [cmv_pkg::ValW-1:0] value_re_i,
  input  logic signed [cmv_pkg::ValW-1:0] value_im_i,
  output logic                            in_ready_o,
  output cmv_pkg::s1_t                    s1_o
);

  logic [2*cmv_pkg::ValW-1:0] vec_mem [cmv_pkg::MaxColumns];
  logic [2*cmv_pkg::ValW-1:0] rd_q;

  logic [cmv_pkg::LoadW-1:0] load_pos_q;
  logic [cmv_pkg::ColW-1:0]  col_pos_q;
  logic [cmv_pkg::RowW-1:0]  row_pos_q;

  logic                            s1_valid_q;
  logic                            s1_end_q;
  logic                            s1_last_q;
  logic [cmv_pkg::RowW-1:0]        s1_row_q;
  logic signed [cmv_pkg::ValW-1:0] s1_ar_q;
  logic signed [cmv_pkg::ValW-1:0] s1_ai_q;

  logic accept;
  logic mat_acc;
  logic load_we;
  logic col_end;
  logic row_last;

  assign in_ready_o = advance_i;
  assign accept     = in_valid_i & advance_i;
  assign mat_acc    = accept & (func_i == cmv_pkg::FuncMatElem);
  assign load_we    = accept & (func_i == cmv_pkg::FuncVecLoad) & ~load_pos_q[cmv_pkg::LoadW-1];

  // end of row and end of matrix
  assign col_end  = ({1'b0, col_pos_q} + cmv_pkg::ColTotW'(1)) >= cfg_i.cols;
  assign row_last = ({1'b0, row_pos_q} + cmv_pkg::RowTotW'(1)) >= cfg_i.rows;

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
    end else begin
      if (load_we)
        load_pos_q <= load_pos_q + cmv_pkg::LoadW'(1);
      if (mat_acc) begin
        if (col_end) begin
          col_pos_q <= '0;
          row_pos_q <= row_last ? '0 : row_pos_q + cmv_pkg::RowW'(1);
        end else begin
          col_pos_q <= col_pos_q + cmv_pkg::ColW'(1);
        end
      end
    end
  end

  // vector store, registered read
  always_ff @(posedge clk_i) begin
    if (load_we)
      vec_mem[load_pos_q[cmv_pkg::ColW-1:0]] <= {value_re_i, value_im_i};
    if (advance_i)
      rd_q <= vec_mem[col_pos_q];
  end

  // operand stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      s1_valid_q <= 1'b0;
    else if (advance_i)
      s1_valid_q <= mat_acc;
  end

  // operand stage payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_end_q  <= col_end;
      s1_last_q <= row_last;
      s1_row_q  <= row_pos_q;
      s1_ar_q   <= value_re_i;
      s1_ai_q   <= value_im_i;
    end
  end

  assign s1_o.valid   = s1_valid_q;
  assign s1_o.row_end = s1_end_q;
  assign s1_o.last    = s1_last_q;
  assign s1_o.row_idx = s1_row_q;
  assign s1_o.ar      = s1_ar_q;
  assign s1_o.ai      = s1_ai_q;
  assign s1_o.br      = rd_q[2*cmv_pkg::ValW-1:cmv_pkg::ValW];
  assign s1_o.bi      = rd_q[cmv_pkg::ValW-1:0];

endmodule

FILE: design/cmv_mac.sv
// complex multiply stage, 48-bit accumulators and the result register
// depends on cmv_pkg and complex_matrix_vector_multiply_top_assert.svh
`include "complex_matrix_vector_multiply_top_assert.svh"

module cmv_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmv_pkg::s1_t                    s1_i,
  output logic                            advance_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [cmv_pkg::RowW-1:0]        row_index_o,
  output logic signed [cmv_pkg::AccW-1:0] sum_re_o,
  output logic signed [cmv_pkg::AccW-1:0] sum_im_o,
  output logic                            last_row_o
);

  localparam int ExtW = cmv_pkg::AccW - cmv_pkg::ProdW;

  logic signed [2*cmv_pkg::ValW-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [cmv_pkg::ProdW-1:0]  pre_d, pim_d;

  logic                             s2_valid_q;
  logic                             s2_end_q;
  logic                             s2_last_q;
  logic [cmv_pkg::RowW-1:0]         s2_row_q;
  logic signed [cmv_pkg::ProdW-1:0] s2_pre_q;
  logic signed [cmv_pkg::ProdW-1:0] s2_pim_q;

  logic [cmv_pkg::AccW-1:0] acc_re_q, acc_im_q;
  logic [cmv_pkg::AccW-1:0] sum_re, sum_im;

  logic                     out_valid_q;
  logic [cmv_pkg::RowW-1:0] out_row_q;
  logic [cmv_pkg::AccW-1:0] out_re_q, out_im_q;
  logic                     out_last_q;

  logic out_load;

  // the pipe only halts when a row sum is due and the result slot is full and not being read
  assign advance_o = ~(s2_valid_q & s2_end_q & out_valid_q & ~out_ready_i);
  assign out_load  = advance_o & s2_valid_q & s2_end_q;

  // complex product, exact
  assign p_rr  = s1_i.ar * s1_i.br;
  assign p_ii  = s1_i.ai * s1_i.bi;
  assign p_ir  = s1_i.ai * s1_i.br;
  assign p_ri  = s1_i.ar * s1_i.bi;
  assign pre_d = {p_rr[2*cmv_pkg::ValW-1], p_rr} - {p_ii[2*cmv_pkg::ValW-1], p_ii};
  assign pim_d = {p_ir[2*cmv_pkg::ValW-1], p_ir} + {p_ri[2*cmv_pkg::ValW-1], p_ri};

  // product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      s2_valid_q <= 1'b0;
    else if (advance_o)
      s2_valid_q <= s1_i.valid;
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      s2_end_q  <= s1_i.row_end;
      s2_last_q <= s1_i.last;
      s2_row_q  <= s1_i.row_idx;
      s2_pre_q  <= pre_d;
      s2_pim_q  <= pim_d;
    end
  end

  // accumulate, wrapping at 48 bits
  assign sum_re = acc_re_q + {{ExtW{s2_pre_q[cmv_pkg::ProdW-1]}}, s2_pre_q};
  assign sum_im = acc_im_q + {{ExtW{s2_pim_q[cmv_pkg::ProdW-1]}}, s2_pim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (advance_o && s2_valid_q) begin
      if (s2_end_q) begin
        acc_re_q <= '0;
        acc_im_q <= '0;
      end else begin
        acc_re_q <= sum_re;
        acc_im_q <= sum_im;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      out_valid_q <= 1'b0;
    else
      out_valid_q <= (out_valid_q & ~out_ready_i) | out_load;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= s2_row_q;
      out_re_q   <= sum_re;
      out_im_q   <= sum_im;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign sum_re_o    = out_re_q;
  assign sum_im_o    = out_im_q;
  assign last_row_o  = out_last_q;

  // checks
  `CMV_ASSERT_IMP(a_halt_only_on_row_end, !advance_o, s2_valid_q && s2_end_q && out_valid_q)
  `CMV_ASSERT_NXT(a_acc_cleared_after_row, out_load, acc_re_q == '0 && acc_im_q == '0)
  `CMV_ASSERT_IMP(a_result_from_row_end, $rose(out_valid_q), $past(out_load))

endmodule

FILE: design/complex_matrix_vector_multiply_top.sv
// channel   dir  handshake      payload
// in_i      in   valid/ready    func, value_re, value_im (Q8.8)
// out_o     out  valid/ready    row_index, sum_re, sum_im (Q32.16, 48 bit), last_row
// apb       in   psel/penable   row_total at 0x0, column_total at 0x4
//
// one item per cycle unless a stalled result halts the pipe; a row result is registered in the
// result register after the operand stage (with the vector store read) and the product stage
// the vector store is a 1024 x 32 single-write memory with a registered read port
// reset clears counters, accumulators and valids; the store holds no reset value
// a stalled result only blocks the input when the next row sum is due in the product stage
// depends on cmv_pkg, cmv_item_if, cmv_result_if, cmv_cfg_regs, cmv_seq, cmv_mac
module complex_matrix_vector_multiply_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cmv_item_if.sink                  in_i,
  cmv_result_if.source              out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cmv_pkg::AddrW-1:0] paddr,
  input  logic [cmv_pkg::DataW-1:0] pwdata,
  output logic [cmv_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  cmv_pkg::cfg_t cfg;
  cmv_pkg::s1_t  s1;
  logic          advance;

  // configuration registers
  cmv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // vector store and sequencing
  cmv_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .advance_i  (advance),
    .in_valid_i (in_i.valid),
    .func_i     (in_i.func),
    .value_re_i (in_i.value_re),
    .value_im_i (in_i.value_im),
    .in_ready_o (in_i.ready),
    .s1_o       (s1)
  );

  // multiply-accumulate and result
  cmv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1),
    .advance_o   (advance),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .row_index_o (out_o.row_index),
    .sum_re_o    (out_o.sum_re),
    .sum_im_o    (out_o.sum_im),
    .last_row_o  (out_o.last_row)
  );

endmodule

FILE: sim/complex_matrix_vector_multiply_top_tb.sv
// self-checking testbench for the complex matrix-vector multiplier: loads vector items,
// streams matrix items under random gaps and stalls, checks every row sum against a predictor
// depends on cmv_pkg, cmv_item_if, cmv_result_if and complex_matrix_vector_multiply_top
module complex_matrix_vector_multiply_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected row sum
  typedef struct packed {
    logic [cmv_pkg::RowW-1:0] row;
    logic [cmv_pkg::AccW-1:0] re;
    logic [cmv_pkg::AccW-1:0] im;
    logic                     last;
  } row_sum_t;

  // row sum predictor and store of expected row sums
  class row_sum_board;
    int unsigned                     row_total_raw;
    int unsigned                     col_total_raw;
    logic signed [cmv_pkg::ValW-1:0] vec_re[cmv_pkg::MaxColumns];
    logic signed [cmv_pkg::ValW-1:0] vec_im[cmv_pkg::MaxColumns];
    int unsigned                     loaded;
    int unsigned                     col_pos;
    int unsigned                     row_pos;
    logic [cmv_pkg::AccW-1:0]        acc_re;
    logic [cmv_pkg::AccW-1:0]        acc_im;
    row_sum_t                        expected_rows[$];
    int unsigned                     mismatches;
    int unsigned                     rows_checked;
    int unsigned                     elements;
    int unsigned                     vec_loads;
    int unsigned                     dropped_loads;

    function new();
      row_total_raw = 1;
      col_total_raw = 1;
      loaded        = 0;
      col_pos       = 0;
      row_pos       = 0;
      acc_re        = '0;
      acc_im        = '0;
      mismatches    = 0;
      rows_checked  = 0;
      elements      = 0;
      vec_loads     = 0;
      dropped_loads = 0;
    endfunction

    function int unsigned clamp_count(input int unsigned v, input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void set_reg(input logic idx, input int unsigned value);
      if (idx == cmv_pkg::RegRowTotal) row_total_raw = value & 32'h1ffff;
      else col_total_raw = value & 32'h7ff;
    endfunction

    // one accepted input item
    function void note_item(input logic fn, input logic signed [cmv_pkg::ValW-1:0] re,
                            input logic signed [cmv_pkg::ValW-1:0] im);
      longint      pr;
      longint      pi;
      int unsigned cols;
      int unsigned rows;
      row_sum_t    sum;
      if (fn == cmv_pkg::FuncVecLoad) begin
        vec_loads++;
        if (loaded < cmv_pkg::MaxColumns) begin
          vec_re[loaded] = re;
          vec_im[loaded] = im;
          loaded++;
        end else begin
          dropped_loads++;
        end
        return;
      end
      elements++;
      cols = clamp_count(col_total_raw, cmv_pkg::MaxColumns);
      rows = clamp_count(row_total_raw, cmv_pkg::MaxRows);
      // complex multiply-accumulate, wrapping at the accumulator width
      pr = longint'(re) * longint'(vec_re[col_pos]) - longint'(im) * longint'(vec_im[col_pos]);
      pi = longint'(im) * longint'(vec_re[col_pos]) + longint'(re) * longint'(vec_im[col_pos]);
      acc_re = acc_re + cmv_pkg::AccW'(pr);
      acc_im = acc_im + cmv_pkg::AccW'(pi);
      if (col_pos + 1 < cols) begin
        col_pos++;
        return;
      end
      // row complete
      sum.row  = cmv_pkg::RowW'(row_pos);
      sum.re   = acc_re;
      sum.im   = acc_im;
      sum.last = (row_pos + 1 >= rows);
      expected_rows.push_back(sum);
      acc_re  = '0;
      acc_im  = '0;
      col_pos = 0;
      row_pos = sum.last ? 0 : ((row_pos + 1) & 32'hffff);
    endfunction

    // one accepted row sum against the oldest expectation
    function void check_row(input logic [cmv_pkg::RowW-1:0] row,
                            input logic [cmv_pkg::AccW-1:0] re,
                            input logic [cmv_pkg::AccW-1:0] im, input logic last);
      row_sum_t want;
      if (expected_rows.size() == 0) begin
        $display("%0t ns: unexpected row sum: row %0d re %h im %h last %b",
                 $time, row, re, im, last);
        mismatches++;
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (want.row !== row || want.re !== re || want.im !== im || want.last !== last) begin
        $display("%0t ns: row sum mismatch: expected row %0d re %h im %h last %b,",
                 $time, want.row, want.re, want.im, want.last);
        $display("    got row %0d re %h im %h last %b", row, re, im, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cmv_pkg::AddrW-1:0]     paddr;
  logic [cmv_pkg::DataW-1:0]     pwdata;
  logic [cmv_pkg::DataW-1:0]     prdata;
  logic                          pready;
  bit                            steady;
  row_sum_board                  board;

  cmv_item_if   item_ch ();
  cmv_result_if row_ch ();

  complex_matrix_vector_multiply_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (item_ch),
    .out_o   (row_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // random element value, extremes now and then
  function automatic logic signed [cmv_pkg::ValW-1:0] rand_value();
    case ($urandom_range(7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      default: return cmv_pkg::ValW'($urandom);
    endcase
  endfunction

  // register write: setup then access phase
  task automatic write_reg(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // present one item, with random gaps ahead of it
  task automatic push_item(input logic fn, input logic signed [cmv_pkg::ValW-1:0] re,
                           input logic signed [cmv_pkg::ValW-1:0] im);
    while (!steady && $urandom_range(99) < 32) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid    <= 1'b1;
    item_ch.func     <= fn;
    item_ch.value_re <= re;
    item_ch.value_im <= im;
    do @(posedge clk_i); while (!item_ch.ready);
    board.note_item(fn, re, im);
  endtask

  // random matrix items, with vector loads mixed in and forced where a column is not loaded
  task automatic run_segment(input int unsigned count, input int unsigned load_pct);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (board.col_pos >= board.loaded || $urandom_range(99) < load_pct) begin
        push_item(cmv_pkg::FuncVecLoad, rand_value(), rand_value());
      end else begin
        push_item(cmv_pkg::FuncMatElem, rand_value(), rand_value());
        sent++;
      end
    end
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (board.expected_rows.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // result side: check accepted row sums, random stalls
  initial begin
    row_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && row_ch.valid && row_ch.ready)
        board.check_row(row_ch.row_index, row_ch.sum_re, row_ch.sum_im, row_ch.last_row);
      row_ch.ready <= steady || ($urandom_range(99) >= 32);
    end
  end

  // stimulus
  initial begin
    int unsigned cols_raw;
    int unsigned rows_raw;
    board            = new();
    steady           = 1'b0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    item_ch.valid    = 1'b0;
    item_ch.func     = cmv_pkg::FuncVecLoad;
    item_ch.value_re = '0;
    item_ch.value_im = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-by-one matrix at reset sizes, extreme values
    push_item(cmv_pkg::FuncVecLoad, 16'sd32767, -16'sd32768);
    push_item(cmv_pkg::FuncMatElem, -16'sd32768, -16'sd32768);
    push_item(cmv_pkg::FuncMatElem, 16'sd32767, 16'sd32767);
    push_item(cmv_pkg::FuncMatElem, -16'sd32768, 16'sd32767);
    push_item(cmv_pkg::FuncMatElem, 16'sd0, 16'sd0);
    settle();
    // zero sizes count as one
    write_reg(cmv_pkg::RegRowTotal, 0);
    write_reg(cmv_pkg::RegColTotal, 0);
    push_item(cmv_pkg::FuncMatElem, -16'sd1, 16'sd1);
    push_item(cmv_pkg::FuncVecLoad, -16'sd32768, 16'sd32767);
    push_item(cmv_pkg::FuncVecLoad, -16'sd1, -16'sd1);
    push_item(cmv_pkg::FuncVecLoad, 16'sd0, 16'sd1);
    settle();
    // 2 x 4 matrix with a vector load between matrix items
    write_reg(cmv_pkg::RegColTotal, 4);
    write_reg(cmv_pkg::RegRowTotal, 2);
    push_item(cmv_pkg::FuncMatElem, 16'sd32767, -16'sd32768);
    push_item(cmv_pkg::FuncMatElem, -16'sd32768, -16'sd32768);
    push_item(cmv_pkg::FuncVecLoad, 16'sd1, -16'sd1);
    push_item(cmv_pkg::FuncMatElem, 16'sd32767, 16'sd32767);
    push_item(cmv_pkg::FuncMatElem, -16'sd1, 16'sd256);
    push_item(cmv_pkg::FuncMatElem, 16'sd256, -16'sd1);
    push_item(cmv_pkg::FuncMatElem, -16'sd32768, 16'sd32767);
    push_item(cmv_pkg::FuncMatElem, 16'sd32767, -16'sd32768);
    push_item(cmv_pkg::FuncMatElem, 16'sd0, -16'sd32768);
    settle();

    // random segments; sizes change between them, often in the middle of a row
    for (int seg = 0; seg < 20; seg++) begin
      steady = (seg >= 9 && seg < 14);
      case ($urandom_range(9))
        0:       cols_raw = 0;
        1:       cols_raw = 1;
        default: cols_raw = $urandom_range(2, 8);
      endcase
      case ($urandom_range(9))
        0:       rows_raw = 0;
        1:       rows_raw = cmv_pkg::MaxRows;
        2:       rows_raw = 32'h1ffff;
        3:       rows_raw = 1;
        default: rows_raw = $urandom_range(2, 6);
      endcase
      if (seg == 0 || $urandom_range(3) != 0) write_reg(cmv_pkg::RegColTotal, cols_raw);
      write_reg(cmv_pkg::RegRowTotal, rows_raw);
      run_segment($urandom_range(15, 30), 20);
      settle();
    end
    steady = 1'b0;
    repeat (10) @(posedge clk_i);

    $display("run covered %0d vector loads (%0d dropped), %0d matrix items",
             board.vec_loads, board.dropped_loads, board.elements);
    $display("%0d row sums checked, %0d mismatches", board.rows_checked, board.mismatches);
    if (board.mismatches == 0 && board.expected_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cmv_pkg.sv
design/cmv_item_if.sv
design/cmv_result_if.sv
design/cmv_cfg_regs.sv
design/cmv_seq.sv
design/cmv_mac.sv
design/complex_matrix_vector_multiply_top.sv
sim/complex_matrix_vector_multiply_top_tb.sv
